// ===== design/bpc_pkg.sv =====
// bpc_pkg: shared types and constants for the button press classifier
// no dependencies; used by the interfaces, bpc_core and the top level
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

   localparam int unsigned CountWidth = 8;
   localparam int unsigned CodeWidth  = 2;

   localparam logic [CountWidth-1:0] CountMax   = {CountWidth{1'b1}};
   localparam logic [CountWidth-1:0] LimitReset = CountWidth'(10);

   // reported event codes on the result channel
   typedef enum logic [CodeWidth-1:0] {
      CODE_SHORT = 2'd0,
      CODE_LONG  = 2'd1,
      CODE_HOLD  = 2'd2
   } code_type;

   // record of the last reported event
   typedef enum logic [1:0] {
      REC_NONE  = 2'd0,
      REC_SHORT = 2'd1,
      REC_LONG  = 2'd2,
      REC_HOLD  = 2'd3
   } rec_type;

   typedef struct packed {
      logic [CountWidth-1:0] down_ticks;
      logic [CountWidth-1:0] up_ticks;
      rec_type               last_event;
   } state_type;

   typedef struct packed {
      logic     valid;
      code_type code;
   } event_type;

endpackage

`default_nettype wire

// ===== design/bpc_if.sv =====
// bpc_req_if and bpc_rsp_if: valid/ready channels of the classifier
// depends on bpc_pkg for the payload widths
`timescale 1ns / 1ps
`default_nettype none

interface bpc_req_if;
   logic valid;
   logic ready;
   logic pressed;

   modport source (output valid, output pressed, input ready);
   modport sink   (input valid, input pressed, output ready);
endinterface

interface bpc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bpc_pkg::CodeWidth-1:0]   event_code;

   modport source (output valid, output event_code, input ready);
   modport sink   (input valid, input event_code, output ready);
endinterface

`default_nettype wire

// ===== design/bpc_core.sv =====
// bpc_core: next-state and event logic for one sampled button level
// depends on bpc_pkg for the state and event types
`timescale 1ns / 1ps
`default_nettype none

module bpc_core (
   input  var bpc_pkg::state_type                  state,
   input  var logic                                pressed,
   input  var logic [bpc_pkg::CountWidth-1:0]      press_limit,
   output bpc_pkg::state_type                      state_next,
   output bpc_pkg::event_type                      evt
);

   logic [bpc_pkg::CountWidth-1:0] down_inc;
   logic [bpc_pkg::CountWidth-1:0] up_inc;
   bpc_pkg::rec_type               rec;

   always_comb begin
      down_inc = (state.down_ticks == bpc_pkg::CountMax) ? bpc_pkg::CountMax
                                                         : state.down_ticks + 1'b1;
      up_inc   = (state.up_ticks == bpc_pkg::CountMax) ? bpc_pkg::CountMax
                                                       : state.up_ticks + 1'b1;
      rec        = state.last_event;
      evt.valid  = 1'b0;
      evt.code   = bpc_pkg::CODE_SHORT;
      state_next = state;

      if (pressed) begin
         state_next.down_ticks = down_inc;
         state_next.up_ticks   = '0;
         if (down_inc > press_limit) begin
            priority if (state.last_event == bpc_pkg::REC_NONE) begin
               rec       = bpc_pkg::REC_LONG;
               evt.valid = 1'b1;
               evt.code  = bpc_pkg::CODE_LONG;
            end else if (state.last_event == bpc_pkg::REC_SHORT ||
                         state.last_event == bpc_pkg::REC_HOLD) begin
               rec       = bpc_pkg::REC_HOLD;
               evt.valid = 1'b1;
               evt.code  = bpc_pkg::CODE_HOLD;
            end else begin
               rec = state.last_event;
            end
         end
      end else begin
         state_next.up_ticks   = up_inc;
         state_next.down_ticks = '0;
         priority if (state.down_ticks != '0 && state.down_ticks < press_limit) begin
            rec       = bpc_pkg::REC_SHORT;
            evt.valid = 1'b1;
            evt.code  = bpc_pkg::CODE_SHORT;
         end else if (state.last_event == bpc_pkg::REC_LONG ||
                      state.last_event == bpc_pkg::REC_HOLD) begin
            rec = bpc_pkg::REC_NONE;
         end else begin
            rec = state.last_event;
         end
      end

      // long release clears the record
      if (state_next.up_ticks > press_limit) begin
         rec = bpc_pkg::REC_NONE;
      end
      state_next.last_event = rec;
   end

endmodule

`default_nettype wire

// ===== design/button_press_classifier.sv =====
// button_press_classifier: top level, input register, state and result register
// depends on bpc_pkg, bpc_req_if, bpc_rsp_if and bpc_core
//
//   channel   dir   handshake      payload
//   req_chan  in    valid/ready    pressed     (1 bit, sampled button level)
//   rsp_chan  out   valid/ready    event_code  (2 bits: short, long, hold)
//   csr       in    csr_wr_en      csr_wr_data (8 bits, press_limit)
//
// one item a cycle sustained while the result is not stalled; each item is held in
// the input register and its event, if any, in the result register shown on rsp_chan
// the counters and record update as the item leaves the input register, so the
// next item always sees the state its predecessor left
// an item with no event produces no result and only occupies the input stage
// reset (synchronous) clears counters, record, valids and sets press_limit to 10
// a stalled result holds a full input stage; req_chan.ready then follows rsp_chan.ready
`timescale 1ns / 1ps
`default_nettype none

module button_press_classifier (
   input  var logic                              clock,
   input  var logic                              reset,
   bpc_req_if.sink                               req_chan,
   bpc_rsp_if.source                             rsp_chan,
   input  var logic                              csr_wr_en,
   input  var logic [bpc_pkg::CountWidth-1:0]    csr_wr_data
);

   // configuration
   logic [bpc_pkg::CountWidth-1:0] limit_ff;

   // input stage
   logic s1_valid_ff, s1_valid_in;
   logic s1_pressed_ff;

   // classifier state
   bpc_pkg::state_type state_ff, state_in;
   bpc_pkg::event_type evt;

   // result stage
   logic              rsp_valid_ff, rsp_valid_in;
   bpc_pkg::code_type rsp_code_ff;

   logic advance;    // input stage may move on into the result stage
   logic req_take;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   bpc_core u_core (
      .state       (state_ff),
      .pressed     (s1_pressed_ff),
      .press_limit (limit_ff),
      .state_next  (state_in),
      .evt         (evt)
   );

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = advance ? (s1_valid_ff && evt.valid) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= bpc_pkg::LimitReset;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{down_ticks: '0, up_ticks: '0, last_event: bpc_pkg::REC_NONE};
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         // state moves only with an item leaving the input stage
         if (advance && s1_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pressed_ff <= req_chan.pressed;
      end
      if (advance && s1_valid_ff && evt.valid) begin
         rsp_code_ff <= evt.code;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.event_code = rsp_code_ff;

   // state is frozen while no item leaves the input stage
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && s1_valid_ff) |=> $stable(state_ff))
      else $error("classifier state changed without an item");

   // the two run counters are never both running
   a_counts_exclusive: assert property (@(posedge clock) disable iff (reset)
      state_ff.down_ticks == '0 || state_ff.up_ticks == '0)
      else $error("down and up counts both non-zero");

   // a reported hold leaves a hold on record
   a_hold_recorded: assert property (@(posedge clock) disable iff (reset)
      advance && s1_valid_ff && evt.valid && evt.code == bpc_pkg::CODE_HOLD
      |=> state_ff.last_event == bpc_pkg::REC_HOLD)
      else $error("hold reported but not recorded");

   // a stalled result with a full input stage blocks new items
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready && s1_valid_ff |-> !req_chan.ready)
      else $error("item accepted into a blocked input stage");

   // an item with an event reaches the result stage the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance && s1_valid_ff && evt.valid |=> rsp_valid_ff)
      else $error("event lost on the way to the result stage");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// testbench: self-checking bench for button_press_classifier (short, long and hold events)
// depends on bpc_pkg, bpc_req_if, bpc_rsp_if and the button_press_classifier top level
// a directed script, then random press and release runs under several limits
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int SETTLE_CYCLES   = 4;     // input register plus result register, with margin
   localparam int DRAIN_LIMIT     = 5000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int PHASES          = 10;
   localparam int PHASE_ITEMS     = 130;
   localparam int SCRIPT_ROWS     = 26;

   typedef enum logic {ROW_LEVEL, ROW_LIMIT} row_kind_type;

   // one line of the directed script: a button level or a new press limit,
   // with the event typed in where it is plain to see
   typedef struct {
      row_kind_type                   kind;
      logic [bpc_pkg::CountWidth-1:0] value;
      bit                             typed;
      bit                             fires;
      bpc_pkg::code_type              code;
   } script_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [bpc_pkg::CountWidth-1:0] csr_wr_data;

   bpc_req_if req_chan ();
   bpc_rsp_if rsp_chan ();

   button_press_classifier dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // tracked state of the classifier, updated as each item is accepted
   logic [bpc_pkg::CountWidth-1:0] track_down;
   logic [bpc_pkg::CountWidth-1:0] track_up;
   bpc_pkg::rec_type               track_record;
   logic [bpc_pkg::CountWidth-1:0] track_limit;

   // events still owed by the block, oldest first
   bpc_pkg::code_type pending_codes [$];

   int  error_count = 0;
   int  cycle_count = 0;
   bit  sender_steady = 1'b0;
   bit  receiver_steady = 1'b0;
   bit  hold_off_request = 1'b0;

   script_row_type script [SCRIPT_ROWS] = '{
      // reset limit of 10: a quick tap gives a short press
      '{ROW_LEVEL, 8'd0,   1'b1, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd1,   1'b1, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd0,   1'b1, 1'b1, bpc_pkg::CODE_SHORT},
      // limit of 1: a press soon after a short press turns into holds
      '{ROW_LIMIT, 8'd1,   1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd1,   1'b1, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd1,   1'b1, 1'b1, bpc_pkg::CODE_HOLD},
      '{ROW_LEVEL, 8'd1,   1'b1, 1'b1, bpc_pkg::CODE_HOLD},
      '{ROW_LEVEL, 8'd0,   1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      // record cleared by the release, so the next long hold is a long press
      '{ROW_LEVEL, 8'd1,   1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd1,   1'b1, 1'b1, bpc_pkg::CODE_LONG},
      '{ROW_LEVEL, 8'd1,   1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd0,   1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      // release after exactly the limit reports nothing
      '{ROW_LEVEL, 8'd1,   1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd0,   1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      // limit of zero: first down tick is already a long press
      '{ROW_LIMIT, 8'd0,   1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd1,   1'b1, 1'b1, bpc_pkg::CODE_LONG},
      '{ROW_LEVEL, 8'd0,   1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd0,   1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      // top limit: long press unreachable, short press still works
      '{ROW_LIMIT, 8'd255, 1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd1,   1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd0,   1'b1, 1'b1, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd0,   1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LIMIT, 8'd254, 1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd1,   1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd1,   1'b0, 1'b0, bpc_pkg::CODE_SHORT},
      '{ROW_LEVEL, 8'd0,   1'b1, 1'b1, bpc_pkg::CODE_SHORT}
   };

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("testbench: FAIL");
         $finish;
      end
   end

   // classify one button level against the tracked state; returns 1 when an event fires
   function automatic bit classify_level(input logic level, output bpc_pkg::code_type code);
      bit fires;
      fires = 1'b0;
      code = bpc_pkg::CODE_SHORT;
      if (level) begin
         if (track_down != bpc_pkg::CountMax) track_down = track_down + 1'b1;
         if (track_down > track_limit) begin
            if (track_record == bpc_pkg::REC_NONE) begin
               // first time past the limit with nothing recent
               track_record = bpc_pkg::REC_LONG;
               code = bpc_pkg::CODE_LONG;
               fires = 1'b1;
            end else if (track_record == bpc_pkg::REC_SHORT ||
                         track_record == bpc_pkg::REC_HOLD) begin
               // pressed again soon after a short press, or still holding
               track_record = bpc_pkg::REC_HOLD;
               code = bpc_pkg::CODE_HOLD;
               fires = 1'b1;
            end
         end
         track_up = '0;
      end else begin
         if (track_up != bpc_pkg::CountMax) track_up = track_up + 1'b1;
         if (track_down != 0 && track_down < track_limit) begin
            track_record = bpc_pkg::REC_SHORT;
            code = bpc_pkg::CODE_SHORT;
            fires = 1'b1;
         end else if (track_record == bpc_pkg::REC_LONG ||
                      track_record == bpc_pkg::REC_HOLD) begin
            // letting go after a long press or hold forgets it
            track_record = bpc_pkg::REC_NONE;
         end
         track_down = '0;
      end
      // a long enough quiet spell clears the record
      if (track_up > track_limit) track_record = bpc_pkg::REC_NONE;
      return fires;
   endfunction

   // offer one button level and wait until the block takes it; valid stays high after
   task automatic offer_level(input logic level, input bit typed, input bit typed_fires,
                              input bpc_pkg::code_type typed_code);
      int unsigned gap;
      int unsigned pick;
      bit fires;
      bpc_pkg::code_type code;
      gap = 0;
      if (!sender_steady) begin
         pick = $urandom_range(0, 19);
         if (pick >= 19) gap = $urandom_range(15, 30);
         else if (pick >= 18) gap = $urandom_range(4, 10);
         else if (pick >= 12) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pressed <= level;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      fires = classify_level(level, code);
      if (typed) begin
         fires = typed_fires;
         code = typed_code;
      end
      if (fires) pending_codes.push_back(code);
   endtask

   // stop offering and wait for every owed event, plus the pipeline depth
   task automatic settle_all();
      req_chan.valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // new press limit, written only with the block idle
   task automatic write_limit(input logic [bpc_pkg::CountWidth-1:0] value);
      settle_all();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      track_limit = value;
   endtask

   // result side: random ready, with one long hold-off on request
   initial begin : result_sink
      int unsigned run;
      logic take;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            // long back-pressure so the input stage fills and stalls the sender
            hold_off_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (receiver_steady) begin
               take = 1'b1;
               run = $urandom_range(1, 8);
            end else if ($urandom_range(0, 1) == 1) begin
               take = 1'b1;
               run = $urandom_range(1, 10);
            end else begin
               take = 1'b0;
               run = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            end
            rsp_chan.ready <= take;
            repeat (run) @(posedge clock);
         end
      end
   end

   // compare every accepted event with the oldest one owed
   always @(posedge clock) begin
      bpc_pkg::code_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_codes.size() == 0) begin
            error_count <= error_count + 1;
            $display("%0t: unexpected event, expected none, got %0d",
                     $time, rsp_chan.event_code);
         end else begin
            want = pending_codes.pop_front();
            if (rsp_chan.event_code !== want) begin
               error_count <= error_count + 1;
               $display("%0t: event_code mismatch, expected %0d (%s), got %0d",
                        $time, want, want.name(), rsp_chan.event_code);
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned sent;
      int unsigned len;
      int unsigned pick;
      int unsigned lim;
      int unsigned lo;
      int unsigned wait_cycles;
      logic level;
      bit paused;

      req_chan.valid <= 1'b0;
      req_chan.pressed <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      reset <= 1'b1;
      track_down = '0;
      track_up = '0;
      track_record = bpc_pkg::REC_NONE;
      track_limit = bpc_pkg::LimitReset;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed script
      foreach (script[i]) begin
         if (script[i].kind == ROW_LIMIT) begin
            write_limit(script[i].value);
         end else begin
            offer_level(script[i].value[0], script[i].typed, script[i].fires, script[i].code);
         end
      end

      // random phases: alternating press and release runs around each limit
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: lim = 3;
            1: lim = 1;
            2: lim = 5;
            3: lim = 254;
            4: lim = 255;
            5: lim = 10;
            6: lim = 2;
            default: begin
               lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 24);
            end
         endcase
         write_limit(lim[bpc_pkg::CountWidth-1:0]);
         // phase 2 keeps offering through a long result stall; phase 6 runs flat out
         sender_steady = (phase == 2 || phase == 6);
         receiver_steady = (phase == 6);
         if (phase == 2) hold_off_request = 1'b1;
         paused = 1'b0;
         sent = 0;
         level = 1'b0;
         while (sent < PHASE_ITEMS) begin
            if (phase == 5 && !paused && sent >= PHASE_ITEMS / 2) begin
               // sender pause until the block has caught up
               settle_all();
               paused = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick == 9) begin
               // noise: a few random levels
               len = $urandom_range(1, 6);
               repeat (len) offer_level($urandom_range(0, 1) != 0, 1'b0, 1'b0,
                                        bpc_pkg::CODE_SHORT);
            end else begin
               level = !level;
               if (pick <= 5) begin
                  len = $urandom_range(1, (lim < 40) ? lim + 3 : 40);
               end else if (pick == 6) begin
                  // straddle the limit: one below, exactly, just above
                  lo = (lim > 1) ? lim - 1 : 1;
                  len = $urandom_range(lo, lim + 2);
               end else begin
                  // well past the limit, saturating the counters at the top limits
                  len = $urandom_range(lim + 1, lim + 12);
               end
               repeat (len) offer_level(level, 1'b0, 1'b0, bpc_pkg::CODE_SHORT);
            end
            sent += len;
         end
      end

      // let the last events out, bounded
      req_chan.valid <= 1'b0;
      for (wait_cycles = 0; pending_codes.size() != 0 && wait_cycles < DRAIN_LIMIT;
           wait_cycles++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_codes.size() != 0) begin
         $display("%0t: %0d expected events never arrived, expected %0d more, got none",
                  $time, pending_codes.size(), pending_codes.size());
         error_count = error_count + pending_codes.size();
      end
      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/bpc_pkg.sv
design/bpc_if.sv
design/bpc_core.sv
design/button_press_classifier.sv
test/testbench.sv
